// File: rtl/core/assert_macros.svh
// Assertion macros used by the top level of the frame difference block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge, off while reset is active.
`define FDAT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition never holds on any rising clock edge out of reset.
`define FDAT_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// File: rtl/core/fdat_pkg.sv
// Types and constants of the frame difference adaptive threshold block.
`default_nettype none

package fdat_pkg;

  localparam int unsigned DATA_W     = 24;
  localparam int unsigned FRAC_SHIFT = 20;
  localparam int unsigned PROD_W     = 40;

  localparam logic [7:0] THRESH_MIN   = 8'd10;
  localparam logic [7:0] THRESH_MAX   = 8'd254;
  localparam logic [7:0] MASK_ON      = 8'hFF;
  localparam logic [7:0] MASK_OFF     = 8'h00;

  localparam logic [7:0]  RST_INIT_THR  = 8'd24;
  localparam logic [15:0] RST_LOW_BOUND = 16'd3670;
  localparam logic [15:0] RST_HIGH_BOUND = 16'd4928;
  localparam logic [3:0]  RST_PERIOD    = 4'd4;
  localparam logic [23:0] RST_PIXELS    = 24'd307200;
  localparam logic        RST_COLOR     = 1'b1;

  localparam logic [1:0] KIND_PIXEL = 2'd0;
  localparam logic [1:0] KIND_NOISE = 2'd1;
  localparam logic [1:0] KIND_FRAME = 2'd2;

  localparam logic [2:0] REG_INIT_THR   = 3'd0;
  localparam logic [2:0] REG_LOW_BOUND  = 3'd1;
  localparam logic [2:0] REG_HIGH_BOUND = 3'd2;
  localparam logic [2:0] REG_PERIOD     = 3'd3;
  localparam logic [2:0] REG_PIXELS     = 3'd4;
  localparam logic [2:0] REG_COLOR      = 3'd5;

  typedef enum logic [1:0] {
    ALU_CMP,
    ALU_ABSACC,
    ALU_MUL
  } alu_op_e;

  typedef struct packed {
    alu_op_e           op;
    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] b;
    logic [9:0]        acc;
  } alu_req_t;

  typedef struct packed {
    logic [PROD_W-1:0] res;
    logic              lt;
    logic              eq;
  } alu_rsp_t;

  function automatic logic [7:0] clamp_thr(logic [8:0] t);
    logic [7:0] r;
    if (t < {1'b0, THRESH_MIN}) begin
      r = THRESH_MIN;
    end else if (t > {1'b0, THRESH_MAX}) begin
      r = THRESH_MAX;
    end else begin
      r = t[7:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/fdat_alu.sv
// Shared arithmetic unit: abs-difference accumulate, compare and multiply.
`default_nettype none

module fdat_alu (
  input  fdat_pkg::alu_req_t req_i,
  output fdat_pkg::alu_rsp_t rsp_o
);

  logic [7:0] diff;

  assign diff = (req_i.a[7:0] > req_i.b[7:0]) ? (req_i.a[7:0] - req_i.b[7:0])
                                              : (req_i.b[7:0] - req_i.a[7:0]);

  always_comb begin
    rsp_o.lt = (req_i.a < req_i.b);
    rsp_o.eq = (req_i.a == req_i.b);
    unique case (req_i.op)
      fdat_pkg::ALU_ABSACC: begin
        rsp_o.res = {30'd0, req_i.acc + {2'b00, diff}};
      end
      fdat_pkg::ALU_MUL: begin
        rsp_o.res = {16'd0, req_i.a} * {24'd0, req_i.b[15:0]};
      end
      default: begin
        rsp_o.res = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/core/fdat_store.sv
// Noise report store: one write port, two registered read ports.
`default_nettype none

module fdat_store #(
  parameter int unsigned DEPTH = 8,
  parameter int unsigned IW    = 3
) (
  input  wire                                clk_i,
  input  wire                                we_i,
  input  wire  [IW-1:0]                      waddr_i,
  input  wire  [fdat_pkg::DATA_W-1:0]        wdata_i,
  input  wire  [IW-1:0]                      raddr_a_i,
  input  wire  [IW-1:0]                      raddr_b_i,
  output logic [fdat_pkg::DATA_W-1:0]        rdata_a_o,
  output logic [fdat_pkg::DATA_W-1:0]        rdata_b_o
);

  logic [fdat_pkg::DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_a_o <= mem[raddr_a_i];
    rdata_b_o <= mem[raddr_b_i];
  end

endmodule

`default_nettype wire

// File: rtl/core/frame_diff_adaptive_threshold_top.sv
// Top level of the frame difference motion mask with adaptive threshold.
`default_nettype none

// Motion mask with adaptive threshold. Each input beat carries a kind in
// tuser: a pixel pair, a noise report or a frame start. A pixel pair yields
// one output beat: mask 255 when the absolute channel difference (channel 0
// in gray mode, the sum of three channels in color mode) exceeds the current
// threshold, else 0, together with the threshold applied. Noise reports are
// stored up to MAX_REPORTS; extras are dropped. A frame start, once at least
// calibration_period reports are stored, finds their median, compares
// median/frame_pixels against the two bounds (units of 2^-20), steps the
// threshold by one within 10..254 and empties the store. All arithmetic runs
// on one shared unit (abs-difference accumulate, compare, 16x24 multiply)
// under a sequencer, and the input is not ready while an item is in work.
// For each item: a pixel pair takes one accumulate step per channel plus the
// output load, and waits there if the output beat before it has not been
// taken; a noise report and a frame start without calibration are done on
// the accept; with stored reports, a frame start runs the median search
// that reads two store entries per compare through the store's registered
// read ports.
// The output register lets a new item be accepted while a mask beat waits.
module frame_diff_adaptive_threshold_top #(
  parameter int unsigned MAX_REPORTS = 8
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  // stream input
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  // [7:0] first_ch0, [15:8] first_ch1, [23:16] first_ch2, [31:24] second_ch0,
  // [39:32] second_ch1, [47:40] second_ch2, [71:48] noise_amount
  input  wire  [71:0] s_axis_tdata,
  // [1:0] kind
  input  wire  [1:0]  s_axis_tuser,
  // stream output
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  // [7:0] motion_mask, [15:8] threshold_used
  output logic [15:0] m_axis_tdata,
  // configuration port
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [4:0]  paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned IW   = (MAX_REPORTS > 1) ? $clog2(MAX_REPORTS) : 1;
  localparam int unsigned CW   = $clog2(MAX_REPORTS + 1);
  localparam int unsigned CMPW = (CW > 4) ? CW : 4;
  localparam int unsigned SCW  = fdat_pkg::DATA_W + fdat_pkg::FRAC_SHIFT;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_PIX  = 4'd1;
  localparam logic [3:0] S_OUT  = 4'd2;
  localparam logic [3:0] S_RD   = 4'd3;
  localparam logic [3:0] S_CMP  = 4'd4;
  localparam logic [3:0] S_EVAL = 4'd5;
  localparam logic [3:0] S_MULH = 4'd6;
  localparam logic [3:0] S_CHKH = 4'd7;
  localparam logic [3:0] S_MULL = 4'd8;
  localparam logic [3:0] S_CHKL = 4'd9;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [7:0]  init_thr_q;
  logic [15:0] low_bound_q;
  logic [15:0] high_bound_q;
  logic [3:0]  period_q;
  logic [23:0] pixels_q;
  logic        color_q;

  logic       cfg_we;
  logic [2:0] cfg_idx;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[4:2];
  assign cfg_we  = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_thr_q   <= fdat_pkg::RST_INIT_THR;
      low_bound_q  <= fdat_pkg::RST_LOW_BOUND;
      high_bound_q <= fdat_pkg::RST_HIGH_BOUND;
      period_q     <= fdat_pkg::RST_PERIOD;
      pixels_q     <= fdat_pkg::RST_PIXELS;
      color_q      <= fdat_pkg::RST_COLOR;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        fdat_pkg::REG_INIT_THR:   init_thr_q   <= pwdata[7:0];
        fdat_pkg::REG_LOW_BOUND:  low_bound_q  <= pwdata[15:0];
        fdat_pkg::REG_HIGH_BOUND: high_bound_q <= pwdata[15:0];
        fdat_pkg::REG_PERIOD:     period_q     <= pwdata[3:0];
        fdat_pkg::REG_PIXELS:     pixels_q     <= pwdata[23:0];
        fdat_pkg::REG_COLOR:      color_q      <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      fdat_pkg::REG_INIT_THR:   prdata = {24'd0, init_thr_q};
      fdat_pkg::REG_LOW_BOUND:  prdata = {16'd0, low_bound_q};
      fdat_pkg::REG_HIGH_BOUND: prdata = {16'd0, high_bound_q};
      fdat_pkg::REG_PERIOD:     prdata = {28'd0, period_q};
      fdat_pkg::REG_PIXELS:     prdata = {8'd0, pixels_q};
      fdat_pkg::REG_COLOR:      prdata = {31'd0, color_q};
      default:                  prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sequencer state and datapath registers
  // ---------------------------------------------------------------------------
  logic [3:0]  state_q, state_d;
  logic [7:0]  thr_q, thr_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] i_q, i_d;
  logic [CW-1:0] j_q, j_d;
  logic [CW-1:0] nlt_q, nlt_d;
  logic [CW-1:0] nle_q, nle_d;
  logic [1:0]  ch_q, ch_d;
  logic [9:0]  acc_q, acc_d;
  logic [7:0]  pa_q [3];
  logic [7:0]  pb_q [3];
  logic [fdat_pkg::DATA_W-1:0] vi_q, vi_d;
  logic [fdat_pkg::PROD_W-1:0] prod_q, prod_d;
  logic        mvalid_q, mvalid_d;
  logic [7:0]  mask_q, mask_d;
  logic [7:0]  used_q, used_d;

  logic        in_beat;
  logic        out_free;
  logic [1:0]  ch_last;
  logic [3:0]  period_eff;
  logic [23:0] pixels_eff;
  logic        cal_go;
  logic [CW-1:0] cnt_last;
  logic [CW-1:0] med_k;
  logic        med_found;
  logic [SCW-1:0] scaled;
  logic [SCW-1:0] prod_ext;

  logic        st_we;
  logic [fdat_pkg::DATA_W-1:0] rd_a, rd_b;

  fdat_pkg::alu_req_t alu_req;
  fdat_pkg::alu_rsp_t alu_rsp;

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_beat       = s_axis_tvalid & s_axis_tready;
  assign out_free      = !mvalid_q || m_axis_tready;
  assign ch_last       = color_q ? 2'd2 : 2'd0;
  assign period_eff    = (period_q == 4'd0) ? 4'd1 : period_q;
  assign pixels_eff    = (pixels_q == 24'd0) ? 24'd1 : pixels_q;
  // Calibrate only with enough reports and a non-empty store.
  assign cal_go        = (CMPW'(cnt_q) >= CMPW'(period_eff)) && (cnt_q != '0);
  assign cnt_last      = cnt_q - CW'(1);
  assign med_k         = cnt_q >> 1;
  // Candidate sits at rank k when fewer than k+1 entries are below it and
  // more than k entries are at or below it.
  assign med_found     = (nlt_q <= med_k) && (med_k < nle_q);
  assign scaled        = {vi_q, {fdat_pkg::FRAC_SHIFT{1'b0}}};
  assign prod_ext      = {{(SCW - fdat_pkg::PROD_W){1'b0}}, prod_q};

  // Store a noise report on its beat while there is room, else drop it.
  assign st_we = in_beat && (s_axis_tuser == fdat_pkg::KIND_NOISE) &&
                 (cnt_q < CW'(MAX_REPORTS));

  fdat_store #(
    .DEPTH (MAX_REPORTS),
    .IW    (IW)
  ) u_store (
    .clk_i     (clk_i),
    .we_i      (st_we),
    .waddr_i   (cnt_q[IW-1:0]),
    .wdata_i   (s_axis_tdata[71:48]),
    .raddr_a_i (i_q[IW-1:0]),
    .raddr_b_i (j_q[IW-1:0]),
    .rdata_a_o (rd_a),
    .rdata_b_o (rd_b)
  );

  fdat_alu u_alu (
    .req_i (alu_req),
    .rsp_o (alu_rsp)
  );

  always_comb begin
    state_d  = state_q;
    thr_d    = thr_q;
    cnt_d    = cnt_q;
    i_d      = i_q;
    j_d      = j_q;
    nlt_d    = nlt_q;
    nle_d    = nle_q;
    ch_d     = ch_q;
    acc_d    = acc_q;
    vi_d     = vi_q;
    prod_d   = prod_q;
    mvalid_d = mvalid_q;
    mask_d   = mask_q;
    used_d   = used_q;

    alu_req.op  = fdat_pkg::ALU_CMP;
    alu_req.a   = rd_b;
    alu_req.b   = rd_a;
    alu_req.acc = acc_q;

    // Drop the output beat once taken.
    if (mvalid_q && m_axis_tready) begin
      mvalid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_beat) begin
          case (s_axis_tuser)
            fdat_pkg::KIND_PIXEL: begin
              ch_d    = 2'd0;
              acc_d   = '0;
              state_d = S_PIX;
            end
            fdat_pkg::KIND_NOISE: begin
              if (st_we) begin
                cnt_d = cnt_q + CW'(1);
              end
            end
            fdat_pkg::KIND_FRAME: begin
              if (cal_go) begin
                i_d     = '0;
                j_d     = '0;
                nlt_d   = '0;
                nle_d   = '0;
                state_d = S_RD;
              end
            end
            default: ;
          endcase
        end
      end

      S_PIX: begin
        // Accumulate one channel difference a cycle.
        alu_req.op  = fdat_pkg::ALU_ABSACC;
        alu_req.a   = {16'd0, pa_q[ch_q]};
        alu_req.b   = {16'd0, pb_q[ch_q]};
        acc_d       = alu_rsp.res[9:0];
        ch_d        = ch_q + 2'd1;
        if (ch_q == ch_last) begin
          state_d = S_OUT;
        end
      end

      S_OUT: begin
        // Hold until the output register is free.
        if (out_free) begin
          mvalid_d = 1'b1;
          mask_d   = (acc_q > {2'b00, thr_q}) ? fdat_pkg::MASK_ON : fdat_pkg::MASK_OFF;
          used_d   = thr_q;
          state_d  = S_IDLE;
        end
      end

      S_RD: begin
        state_d = S_CMP;
      end

      S_CMP: begin
        vi_d = rd_a;
        if (alu_rsp.lt) begin
          nlt_d = nlt_q + CW'(1);
        end
        if (alu_rsp.lt || alu_rsp.eq) begin
          nle_d = nle_q + CW'(1);
        end
        if (j_q == cnt_last) begin
          state_d = S_EVAL;
        end else begin
          j_d     = j_q + CW'(1);
          state_d = S_RD;
        end
      end

      S_EVAL: begin
        if (med_found) begin
          state_d = S_MULH;
        end else begin
          // Advance to the next candidate.
          i_d     = i_q + CW'(1);
          j_d     = '0;
          nlt_d   = '0;
          nle_d   = '0;
          state_d = S_RD;
        end
      end

      S_MULH: begin
        alu_req.op = fdat_pkg::ALU_MUL;
        alu_req.a  = pixels_eff;
        alu_req.b  = {8'd0, high_bound_q};
        prod_d     = alu_rsp.res;
        state_d    = S_CHKH;
      end

      S_CHKH: begin
        if (scaled > prod_ext) begin
          thr_d = fdat_pkg::clamp_thr({1'b0, thr_q} + 9'd1);
        end
        state_d = S_MULL;
      end

      S_MULL: begin
        alu_req.op = fdat_pkg::ALU_MUL;
        alu_req.a  = pixels_eff;
        alu_req.b  = {8'd0, low_bound_q};
        prod_d     = alu_rsp.res;
        state_d    = S_CHKL;
      end

      S_CHKL: begin
        if (scaled < prod_ext) begin
          thr_d = fdat_pkg::clamp_thr({1'b0, thr_q} - 9'd1);
        end
        cnt_d   = '0;
        state_d = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    // A write of the initial threshold reloads the working threshold.
    if (cfg_we && (cfg_idx == fdat_pkg::REG_INIT_THR)) begin
      thr_d = fdat_pkg::clamp_thr({1'b0, pwdata[7:0]});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      thr_q    <= fdat_pkg::clamp_thr({1'b0, fdat_pkg::RST_INIT_THR});
      cnt_q    <= '0;
      i_q      <= '0;
      j_q      <= '0;
      nlt_q    <= '0;
      nle_q    <= '0;
      ch_q     <= '0;
      mvalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      thr_q    <= thr_d;
      cnt_q    <= cnt_d;
      i_q      <= i_d;
      j_q      <= j_d;
      nlt_q    <= nlt_d;
      nle_q    <= nle_d;
      ch_q     <= ch_d;
      mvalid_q <= mvalid_d;
    end
  end

  // Payload registers, no reset.
  always_ff @(posedge clk_i) begin
    acc_q  <= acc_d;
    vi_q   <= vi_d;
    prod_q <= prod_d;
    mask_q <= mask_d;
    used_q <= used_d;
    if (in_beat && (s_axis_tuser == fdat_pkg::KIND_PIXEL)) begin
      pa_q[0] <= s_axis_tdata[7:0];
      pa_q[1] <= s_axis_tdata[15:8];
      pa_q[2] <= s_axis_tdata[23:16];
      pb_q[0] <= s_axis_tdata[31:24];
      pb_q[1] <= s_axis_tdata[39:32];
      pb_q[2] <= s_axis_tdata[47:40];
    end
  end

  assign m_axis_tvalid = mvalid_q;
  assign m_axis_tdata  = {used_q, mask_q};

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
`include "assert_macros.svh"

  `FDAT_ASSERT(a_thr_range, m_axis_tvalid |-> (m_axis_tdata[15:8] >= fdat_pkg::THRESH_MIN && m_axis_tdata[15:8] <= fdat_pkg::THRESH_MAX), "threshold out of range")
  `FDAT_ASSERT(a_mask_code, m_axis_tvalid |-> (m_axis_tdata[7:0] == fdat_pkg::MASK_ON || m_axis_tdata[7:0] == fdat_pkg::MASK_OFF), "bad mask value")
  `FDAT_ASSERT(a_median_found, (state_q == S_EVAL && i_q == cnt_last) |-> med_found, "median search ran past the last candidate")
  `FDAT_ASSERT(a_store_cleared, (state_q == S_CHKL) |=> (cnt_q == '0), "store not emptied after calibration")
  `FDAT_ASSERT_NEVER(a_cnt_bound, cnt_q > CW'(MAX_REPORTS), "report count above capacity")

endmodule

`default_nettype wire
